/* rtl/core/svsq_pkg.sv */
// shared types, constants and helpers for the single-qubit gate engine
// no dependencies

package svsq_pkg;

    localparam int QUBITS     = 16;
    localparam int VEC_SIZE   = 1 << QUBITS;
    localparam int AW         = QUBITS;
    localparam int TW         = 4;
    localparam int MW         = 16;
    localparam int AMP_W      = 64;
    localparam int PART_W     = 32;
    localparam int FRAC_W     = 30;
    localparam int PROD_W     = 64;
    localparam int SUM_W      = 36;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 64;

    localparam logic [PART_W-1:0] ONE_Q30 = 32'h4000_0000;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_APPLY = 2'd2,
        CMD_INIT  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        GATE_MATRIX = 3'd0,
        GATE_X      = 3'd1,
        GATE_Y      = 3'd2,
        GATE_Z      = 3'd3,
        GATE_PHASE  = 3'd4
    } gate_t;

    typedef enum logic [2:0] {
        REG_GATE_KIND = 3'd0,
        REG_TARGET    = 3'd1,
        REG_CONTROL   = 3'd2,
        REG_COEF_00   = 3'd3,
        REG_COEF_01   = 3'd4,
        REG_COEF_10   = 3'd5,
        REG_COEF_11   = 3'd6
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_INIT,
        ST_SCAN,
        ST_RD0,
        ST_RD1,
        ST_MUL,
        ST_SUM,
        ST_WR0,
        ST_WR1,
        ST_RESP
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic          mem_we;
        logic [1:0]    wsel;     // 0 input, 1 init, 2 new a0, 3 new a1
        logic [1:0]    asel;     // 0 input addr, 1 counter, 2 i0, 3 i1
        logic          cap_a0;
        logic          cap_a1;
        logic          do_mul;
        logic          do_sum;
        logic          cnt_clr;
        logic          cnt_inc;
        logic          cap_read;
        logic          clr_read;
    } ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic cnt_last;
        logic pair_ok;
        logic gate_ok;
    } sts_t;

    function automatic logic signed [PART_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32'sh7FFF_FFFF);
        lo = SUM_W'(32'sh8000_0000);
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[PART_W-1:0];
    endfunction

endpackage

/* rtl/core/svsq_ram.sv */
// generic single-port ram with registered read
// no dependencies

module svsq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

/* rtl/core/svsq_datapath.sv */
// datapath: config registers, amplitude memory, pair counter, complex multiply-add
// depends on svsq_pkg and svsq_ram

module svsq_datapath import svsq_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [AW-1:0]         in_addr,
    input  logic [PART_W-1:0]     in_real,
    input  logic [PART_W-1:0]     in_imag,
    input  ctl_t                  ctl,
    output sts_t                  sts,
    output logic [PART_W-1:0]     out_real,
    output logic [PART_W-1:0]     out_imag
);

    logic [2:0]            gate_kind_reg;
    logic [TW-1:0]         target_reg;
    logic [MW-1:0]         control_reg;
    logic [AMP_W-1:0]      coef_reg [4];
    logic [AW-1:0]         cnt_reg;
    logic [AMP_W-1:0]      a0_reg;
    logic [AMP_W-1:0]      a1_reg;
    logic [AMP_W-1:0]      new0_reg;
    logic [AMP_W-1:0]      new1_reg;
    logic signed [PROD_W-1:0] prod_reg [16];
    logic [PART_W-1:0]     rd_re_reg;
    logic [PART_W-1:0]     rd_im_reg;

    logic [AW-1:0]         tbit;
    logic [AW-1:0]         cmask;
    logic [AW-1:0]         i0;
    logic [AW-1:0]         i1;
    logic [AW-1:0]         mem_addr;
    logic [AMP_W-1:0]      mem_wdata;
    logic [AMP_W-1:0]      mem_rdata;
    logic signed [PART_W-1:0] op_g [8];
    logic signed [PART_W-1:0] op_x [16];
    logic signed [PART_W-1:0] op_y [16];
    logic signed [SUM_W-1:0]  sh [16];
    logic signed [PART_W-1:0] a0r, a0i, a1r, a1i;
    logic signed [PART_W-1:0] n0r, n0i, n1r, n1i;
    logic [AW-1:0]         ctrl_bits;
    logic                  target_ok;

    assign target_ok = ({1'b0, target_reg} < (TW+1)'(QUBITS));
    assign tbit      = target_ok ? (AW'(1) << target_reg) : '0;
    assign ctrl_bits = AW'(control_reg);
    assign cmask     = ctrl_bits & ~tbit;
    assign i0        = cnt_reg;
    assign i1        = cnt_reg | tbit;

    assign sts.cnt_last = (cnt_reg == {AW{1'b1}});
    assign sts.pair_ok  = ((cnt_reg & tbit) == '0) && ((cnt_reg & cmask) == cmask)
                          && ((MW <= AW) || ((control_reg >> AW) == '0));
    assign sts.gate_ok  = target_ok && (gate_kind_reg <= GATE_PHASE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_kind_reg <= '0;
            target_reg    <= '0;
            control_reg   <= '0;
            for (int k = 0; k < 4; k++)
                coef_reg[k] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GATE_KIND: gate_kind_reg <= cfg_data[2:0];
                REG_TARGET:    target_reg    <= cfg_data[TW-1:0];
                REG_CONTROL:   control_reg   <= cfg_data[MW-1:0];
                REG_COEF_00:   coef_reg[0]   <= cfg_data;
                REG_COEF_01:   coef_reg[1]   <= cfg_data;
                REG_COEF_10:   coef_reg[2]   <= cfg_data;
                REG_COEF_11:   coef_reg[3]   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (ctl.cnt_clr)
            cnt_reg <= '0;
        else if (ctl.cnt_inc)
            cnt_reg <= cnt_reg + AW'(1);
    end

    always_comb
    begin
        unique case (ctl.asel)
            2'd0:    mem_addr = in_addr;
            2'd1:    mem_addr = cnt_reg;
            2'd2:    mem_addr = i0;
            default: mem_addr = i1;
        endcase
        unique case (ctl.wsel)
            2'd0:    mem_wdata = {in_real, in_imag};
            2'd1:    mem_wdata = (cnt_reg == '0) ? {ONE_Q30, 32'h0} : '0;
            2'd2:    mem_wdata = new0_reg;
            default: mem_wdata = new1_reg;
        endcase
    end

    svsq_ram #(.WIDTH(AMP_W), .DEPTH(VEC_SIZE)) u_ram (
        .clk   (clk),
        .we    (ctl.mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.cap_a0)
            a0_reg <= mem_rdata;
        if (ctl.cap_a1)
            a1_reg <= mem_rdata;
    end

    // 16 products: rows 0/1, terms g.re*x.re, g.im*x.im, g.re*x.im, g.im*x.re
    assign a0r = a0_reg[63:32];
    assign a0i = a0_reg[31:0];
    assign a1r = a1_reg[63:32];
    assign a1i = a1_reg[31:0];

    always_comb
    begin
        for (int r = 0; r < 2; r++)
        begin
            for (int c = 0; c < 2; c++)
            begin
                op_g[(r*2+c)*2]   = coef_reg[r*2+c][63:32];
                op_g[(r*2+c)*2+1] = coef_reg[r*2+c][31:0];
                op_x[(r*2+c)*4]   = (c == 0) ? a0r : a1r;
                op_y[(r*2+c)*4]   = op_g[(r*2+c)*2];
                op_x[(r*2+c)*4+1] = (c == 0) ? a0i : a1i;
                op_y[(r*2+c)*4+1] = op_g[(r*2+c)*2+1];
                op_x[(r*2+c)*4+2] = (c == 0) ? a0i : a1i;
                op_y[(r*2+c)*4+2] = op_g[(r*2+c)*2];
                op_x[(r*2+c)*4+3] = (c == 0) ? a0r : a1r;
                op_y[(r*2+c)*4+3] = op_g[(r*2+c)*2+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.do_mul)
            for (int k = 0; k < 16; k++)
                prod_reg[k] <= PROD_W'(op_x[k]) * PROD_W'(op_y[k]);
    end

    always_comb
    begin
        for (int k = 0; k < 16; k++)
            sh[k] = SUM_W'(prod_reg[k] >>> FRAC_W);
    end

    function automatic logic signed [PART_W-1:0] neg32(input logic signed [PART_W-1:0] v);
        return sat32(-SUM_W'(v));
    endfunction

    always_comb
    begin
        n0r = a0r; n0i = a0i; n1r = a1r; n1i = a1i;
        unique case (gate_kind_reg)
            GATE_MATRIX:
            begin
                n0r = sat32(sh[0] - sh[1] + sh[4] - sh[5]);
                n0i = sat32(sh[2] + sh[3] + sh[6] + sh[7]);
                n1r = sat32(sh[8] - sh[9] + sh[12] - sh[13]);
                n1i = sat32(sh[10] + sh[11] + sh[14] + sh[15]);
            end
            GATE_X:
            begin
                n0r = a1r; n0i = a1i; n1r = a0r; n1i = a0i;
            end
            GATE_Y:
            begin
                n0r = a1i; n0i = neg32(a1r); n1r = neg32(a0i); n1i = a0r;
            end
            GATE_Z:
            begin
                n1r = neg32(a1r); n1i = neg32(a1i);
            end
            GATE_PHASE:
            begin
                n1r = sat32(sh[12] - sh[13]);
                n1i = sat32(sh[14] + sh[15]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.do_sum)
        begin
            new0_reg <= {n0r, n0i};
            new1_reg <= {n1r, n1i};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clr_read)
        begin
            rd_re_reg <= '0;
            rd_im_reg <= '0;
        end
        else if (ctl.cap_read)
        begin
            rd_re_reg <= mem_rdata[63:32];
            rd_im_reg <= mem_rdata[31:0];
        end
    end

    assign out_real = rd_re_reg;
    assign out_imag = rd_im_reg;

endmodule

/* rtl/core/svsq_ctrl.sv */
// controller state machine sequencing commands and the gate sweep
// depends on svsq_pkg

module svsq_ctrl import svsq_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  cmd_t in_kind,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output ctl_t ctl
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.cnt_clr = 1'b1;
                    unique case (in_kind)
                        CMD_WRITE:
                        begin
                            ctl.mem_we   = 1'b1;
                            ctl.clr_read = 1'b1;
                            state_next   = ST_RESP;
                        end
                        CMD_READ:  state_next = ST_READ_WAIT;
                        CMD_APPLY:
                        begin
                            ctl.clr_read = 1'b1;
                            state_next   = sts.gate_ok ? ST_SCAN : ST_RESP;
                        end
                        default:
                        begin
                            ctl.clr_read = 1'b1;
                            state_next   = ST_INIT;
                        end
                    endcase
                end
            end
            ST_READ_WAIT:
            begin
                ctl.cap_read = 1'b1;
                state_next   = ST_RESP;
            end
            ST_INIT:
            begin
                ctl.asel    = 2'd1;
                ctl.wsel    = 2'd1;
                ctl.mem_we  = 1'b1;
                ctl.cnt_inc = 1'b1;
                if (sts.cnt_last)
                    state_next = ST_RESP;
            end
            ST_SCAN:
            begin
                ctl.asel = 2'd2;
                if (sts.pair_ok)
                    state_next = ST_RD0;
                else
                begin
                    ctl.cnt_inc = 1'b1;
                    if (sts.cnt_last)
                        state_next = ST_RESP;
                end
            end
            ST_RD0:
            begin
                ctl.asel   = 2'd3;
                ctl.cap_a0 = 1'b1;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                ctl.cap_a1 = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                ctl.do_mul = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                ctl.do_sum = 1'b1;
                state_next = ST_WR0;
            end
            ST_WR0:
            begin
                ctl.asel   = 2'd2;
                ctl.wsel   = 2'd2;
                ctl.mem_we = 1'b1;
                state_next = ST_WR1;
            end
            ST_WR1:
            begin
                ctl.asel    = 2'd3;
                ctl.wsel    = 2'd3;
                ctl.mem_we  = 1'b1;
                ctl.cnt_inc = 1'b1;
                state_next  = sts.cnt_last ? ST_RESP : ST_SCAN;
            end
            ST_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* rtl/core/state_vector_single_qubit_gate.sv */
// top level of the state-vector single-qubit gate engine
// depends on svsq_pkg, svsq_ctrl, svsq_datapath, svsq_ram
//
// usage:
//   s_axis carries one command per transaction (write, read, apply, init).
//   m_axis returns exactly one transaction per command: the amplitude for
//   a read, zeros for the others.
//   cfg_we/cfg_index/cfg_data set gate kind, target, control mask and the
//   four matrix coefficients; write only while no command is in flight.
// sequencing: a write goes straight to the response; a read passes a wait
//   state for the registered memory read; init writes every address; apply
//   scans every index and runs each updated pair through RD0, RD1, MUL, SUM,
//   WR0 and WR1 over the single memory port (two reads and two writes per pair).
// throughput: one command at a time; next command accepted after the
//   response transaction completes.
// reset: state machine idles and config registers clear; the amplitude
//   memory is undefined until written or initialized.
// stall: the response holds on m_axis until tready; no command is taken.

module state_vector_single_qubit_gate import svsq_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // kind, address, in_real, in_imag, pad
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // out_real, out_imag
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctl_t ctl;
    sts_t sts;
    logic [PART_W-1:0] out_real;
    logic [PART_W-1:0] out_imag;

    svsq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_kind   (cmd_t'(s_axis_tdata[1:0])),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .ctl       (ctl)
    );

    svsq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_addr   (s_axis_tdata[AW+1:2]),
        .in_real   (s_axis_tdata[49:18]),
        .in_imag   (s_axis_tdata[81:50]),
        .ctl       (ctl),
        .sts       (sts),
        .out_real  (out_real),
        .out_imag  (out_imag)
    );

    assign m_axis_tdata = {out_imag, out_real};

endmodule
